// File: rtl/piqp_pkg.sv
package piqp_pkg;

   // Default geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 64;

   // Fixed field widths
   localparam int ACTION_W = 2;
   localparam int TAG_W    = 64;
   localparam int RATING_W = 16;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVE   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Command to the first queue for one item
   typedef struct packed {
      logic push;   // insert at slot
      logic pop;    // drop head, shift toward head
   } fq_cmd_type;

endpackage

// File: rtl/piqp_req_if.sv
interface piqp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [piqp_pkg::ACTION_W-1:0]        action;
   logic [piqp_pkg::TAG_W-1:0]           name_tag;
   logic signed [piqp_pkg::RATING_W-1:0] rating;
   logic [piqp_pkg::POS_W-1:0]           position;

   modport source (output valid, action, name_tag, rating, position, input ready);
   modport sink   (input valid, action, name_tag, rating, position, output ready);
endinterface

// File: rtl/piqp_rsp_if.sv
interface piqp_rsp_if #(
   parameter int CNT_W = $clog2(piqp_pkg::QUEUE_DEPTH + 1)
);
   logic                                 valid;
   logic                                 ready;
   logic [piqp_pkg::STATUS_W-1:0]        status;
   logic [CNT_W-1:0]                     first_count;
   logic [CNT_W-1:0]                     second_count;
   logic [piqp_pkg::TAG_W-1:0]           moved_tag;
   logic signed [piqp_pkg::RATING_W-1:0] moved_rating;

   modport source (output valid, status, first_count, second_count, moved_tag,
                   moved_rating, input ready);
   modport sink   (input valid, status, first_count, second_count, moved_tag,
                   moved_rating, output ready);
endinterface

// File: rtl/positional_insert_queue_pair.sv
// Channel  Dir  Handshake     Payload
// req_ch   in   valid/ready   action, name_tag, rating, position
// rsp_ch   out  valid/ready   status, first_count, second_count, moved_tag, moved_rating
//
// One item per cycle sustained while rsp_ch is not stalled; an accepted req loads
// the input register, then the queue update and the result register take it,
// and rsp valid rises with the result register.
// The queues are register stores; per item the first shifts, the second writes its tail.
// Reset (synchronous) empties both queues and both pipeline stages.
// A stalled rsp holds the result register; the input register then holds and
// req_ch.ready drops only once both stages are occupied.
module positional_insert_queue_pair #(
   parameter int QUEUE_DEPTH = piqp_pkg::QUEUE_DEPTH,
   parameter int TAG_BITS    = piqp_pkg::TAG_BITS
) (
   input logic              clock,
   input logic              reset,
   piqp_req_if.sink         req_ch,
   piqp_rsp_if.source       rsp_ch
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CMP_W = (CNT_W > piqp_pkg::POS_W) ? CNT_W : piqp_pkg::POS_W;

   // ---------------- input register ----------------
   logic                                 s1_valid_ff;
   logic [piqp_pkg::ACTION_W-1:0]        s1_action_ff;
   logic [TAG_BITS-1:0]                  s1_tag_ff;
   logic signed [piqp_pkg::RATING_W-1:0] s1_rating_ff;
   logic [piqp_pkg::POS_W-1:0]           s1_pos_ff;

   // ---------------- result register ----------------
   logic                                 rsp_valid_ff;
   logic [piqp_pkg::STATUS_W-1:0]        status_ff;
   logic [CNT_W-1:0]                     fcount_ff;
   logic [CNT_W-1:0]                     scount_ff;
   logic [piqp_pkg::TAG_W-1:0]           mtag_ff;
   logic signed [piqp_pkg::RATING_W-1:0] mrating_ff;

   // ---------------- datapath ----------------
   logic                                 s2_free;     // result register can load
   logic                                 fire;        // s1 item executes this cycle
   logic                                 req_take;
   piqp_pkg::fq_cmd_type                 fq_cmd;
   logic                                 sq_push;
   logic [IDX_W-1:0]                     slot;
   logic [CNT_W-1:0]                     first_count;
   logic [CNT_W-1:0]                     second_count;
   logic [TAG_BITS-1:0]                  head_tag;
   logic signed [piqp_pkg::RATING_W-1:0] head_rating;
   logic [piqp_pkg::STATUS_W-1:0]        status_in;
   logic [CNT_W-1:0]                     fcount_in;
   logic [CNT_W-1:0]                     scount_in;
   logic [piqp_pkg::TAG_W-1:0]           mtag_in;
   logic signed [piqp_pkg::RATING_W-1:0] mrating_in;
   logic [piqp_pkg::POS_W-1:0]           pos_adj;
   logic [CMP_W-1:0]                     pos_m1;
   logic [CMP_W-1:0]                     fill_ext;
   logic [CMP_W-1:0]                     slot_wide;
   logic                                 first_full;
   logic                                 first_empty;
   logic                                 second_full;

   assign s2_free      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s2_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_ch.action;
         s1_tag_ff    <= req_ch.name_tag[TAG_BITS-1:0];  // tag kept to TAG_BITS
         s1_rating_ff <= req_ch.rating;
         s1_pos_ff    <= req_ch.position;
      end
   end

   // Position zero acts as the head; a position past the count appends.
   assign pos_adj   = (s1_pos_ff == '0) ? piqp_pkg::POS_W'(1) : s1_pos_ff;
   assign pos_m1    = CMP_W'(pos_adj) - 1'b1;
   assign fill_ext  = CMP_W'(first_count);
   assign slot_wide = (s1_action_ff == piqp_pkg::ACT_INSERT && pos_m1 < fill_ext) ?
                      pos_m1 : fill_ext;
   assign slot      = slot_wide[IDX_W-1:0];

   assign first_full  = (first_count == CNT_W'(QUEUE_DEPTH));
   assign first_empty = (first_count == '0);
   assign second_full = (second_count == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      fq_cmd     = '0;
      sq_push    = 1'b0;
      status_in  = piqp_pkg::ST_DONE;
      mtag_in    = '0;
      mrating_in = '0;
      case (s1_action_ff)
         piqp_pkg::ACT_APPEND, piqp_pkg::ACT_INSERT: begin
            if (first_full) begin
               status_in = piqp_pkg::ST_FULL;
            end else begin
               fq_cmd.push = fire;
            end
         end
         piqp_pkg::ACT_MOVE: begin
            // empty source is checked ahead of full target
            if (first_empty) begin
               status_in = piqp_pkg::ST_EMPTY;
            end else if (second_full) begin
               status_in = piqp_pkg::ST_FULL;
            end else begin
               fq_cmd.pop = fire;
               sq_push    = fire;
               mtag_in    = piqp_pkg::TAG_W'(head_tag);
               mrating_in = head_rating;
            end
         end
         default: begin
            // unused action: no change, done
         end
      endcase
   end

   // Counts after the step
   always_comb begin
      fcount_in = first_count;
      if (fq_cmd.push) begin
         fcount_in = first_count + 1'b1;
      end else if (fq_cmd.pop) begin
         fcount_in = first_count - 1'b1;
      end
      scount_in = sq_push ? second_count + 1'b1 : second_count;
   end

   piqp_first_q #(
      .DEPTH  (QUEUE_DEPTH),
      .TAG_BW (TAG_BITS),
      .CNT_W  (CNT_W),
      .IDX_W  (IDX_W)
   ) u_first_q (
      .clock       (clock),
      .reset       (reset),
      .cmd         (fq_cmd),
      .slot        (slot),
      .tag         (s1_tag_ff),
      .rating      (s1_rating_ff),
      .fill        (first_count),
      .head_tag    (head_tag),
      .head_rating (head_rating)
   );

   piqp_second_q #(
      .DEPTH  (QUEUE_DEPTH),
      .TAG_BW (TAG_BITS),
      .CNT_W  (CNT_W),
      .IDX_W  (IDX_W)
   ) u_second_q (
      .clock  (clock),
      .reset  (reset),
      .push   (sq_push),
      .tag    (head_tag),
      .rating (head_rating),
      .fill   (second_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff  <= status_in;
         fcount_ff  <= fcount_in;
         scount_ff  <= scount_in;
         mtag_ff    <= mtag_in;
         mrating_ff <= mrating_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.first_count  = fcount_ff;
   assign rsp_ch.second_count = scount_ff;
   assign rsp_ch.moved_tag    = mtag_ff;
   assign rsp_ch.moved_rating = mrating_ff;

   // ---------------- checks ----------------
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == piqp_pkg::ST_EMPTY |-> fcount_ff == '0)
      else $error("empty status with entries in first queue");

   a_moved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != piqp_pkg::ST_DONE |-> mtag_ff == '0 && mrating_ff == '0)
      else $error("moved entry reported on refused item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      first_count <= CNT_W'(QUEUE_DEPTH) && second_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill past depth");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> fcount_ff == first_count && scount_ff == second_count)
      else $error("reported counts differ from queue fill");

endmodule

// File: rtl/piqp_first_q.sv
module piqp_first_q #(
   parameter int DEPTH  = piqp_pkg::QUEUE_DEPTH,
   parameter int TAG_BW = piqp_pkg::TAG_BITS,
   parameter int CNT_W  = $clog2(DEPTH + 1),
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  piqp_pkg::fq_cmd_type                 cmd,
   input  logic [IDX_W-1:0]                     slot,
   input  logic [TAG_BW-1:0]                    tag,
   input  logic signed [piqp_pkg::RATING_W-1:0] rating,
   output logic [CNT_W-1:0]                     fill,
   output logic [TAG_BW-1:0]                    head_tag,
   output logic signed [piqp_pkg::RATING_W-1:0] head_rating
);

   logic [TAG_BW-1:0]                    tags_ff    [DEPTH];
   logic signed [piqp_pkg::RATING_W-1:0] ratings_ff [DEPTH];
   logic [CNT_W-1:0]                     fill_ff;
   logic [CNT_W-1:0]                     fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Each entry sees only itself, its neighbors and the new item.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      always_ff @(posedge clock) begin
         if (cmd.push) begin
            if (IDX_W'(i) == slot) begin
               tags_ff[i]    <= tag;
               ratings_ff[i] <= rating;
            end else if (IDX_W'(i) > slot) begin
               if (i > 0) begin
                  tags_ff[i]    <= tags_ff[(i > 0) ? i - 1 : 0];
                  ratings_ff[i] <= ratings_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (cmd.pop) begin
            if (i < DEPTH - 1) begin
               tags_ff[i]    <= tags_ff[(i < DEPTH - 1) ? i + 1 : i];
               ratings_ff[i] <= ratings_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   assign fill        = fill_ff;
   assign head_tag    = tags_ff[0];
   assign head_rating = ratings_ff[0];

endmodule

// File: rtl/piqp_second_q.sv
module piqp_second_q #(
   parameter int DEPTH  = piqp_pkg::QUEUE_DEPTH,
   parameter int TAG_BW = piqp_pkg::TAG_BITS,
   parameter int CNT_W  = $clog2(DEPTH + 1),
   parameter int IDX_W  = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic [TAG_BW-1:0]                    tag,
   input  logic signed [piqp_pkg::RATING_W-1:0] rating,
   output logic [CNT_W-1:0]                     fill
);

   logic [TAG_BW-1:0]                    tags_mem    [DEPTH];
   logic signed [piqp_pkg::RATING_W-1:0] ratings_mem [DEPTH];
   logic [CNT_W-1:0]                     fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (push) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // Tail write; push is only issued below full, so the index fits.
   always_ff @(posedge clock) begin
      if (push) begin
         tags_mem[fill_ff[IDX_W-1:0]]    <= tag;
         ratings_mem[fill_ff[IDX_W-1:0]] <= rating;
      end
   end

   assign fill = fill_ff;

endmodule

// File: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import piqp_pkg::*;

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   // Action code 3 is undefined: the block must leave both queues alone and report done
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   // Tags are kept to the low TAG_BITS bits
   localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);
   // Long output hold used to back the pipeline up into the input channel
   localparam int HOLD_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic [TAG_W-1:0]           name_tag;
      logic signed [RATING_W-1:0] rating;
      logic [POS_W-1:0]           position;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic [COUNT_W-1:0]         first_count;
      logic [COUNT_W-1:0]         second_count;
      logic [TAG_W-1:0]           moved_tag;
      logic signed [RATING_W-1:0] moved_rating;
   } result_type;

   typedef struct packed {
      logic [TAG_W-1:0]           tag;
      logic signed [RATING_W-1:0] rating;
   } entry_type;

   // Scoreboard: mirrors both queues and holds the results still owed by the block
   class queue_pair_tracker;
      entry_type  first_q[$];
      entry_type  second_q[$];
      result_type owed_q[$];
      int         errors;
      int         accepted;
      int         status_seen[4];
      int         first_peak;
      int         second_peak;

      function void note_request(request_type rq);
         result_type  res;
         entry_type   ent;
         int unsigned slot;
         int unsigned place;
         res        = '0;
         res.status = ST_DONE;
         ent.tag    = rq.name_tag & TAG_MASK;
         ent.rating = rq.rating;
         accepted++;
         case (rq.action)
            ACT_APPEND, ACT_INSERT: begin
               if (first_q.size() >= QUEUE_DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  slot = first_q.size();
                  if (rq.action == ACT_INSERT) begin
                     // position 0 counts as the head; past the count means append
                     place = (rq.position == 0) ? 1 : rq.position;
                     if (place - 1 < slot) slot = place - 1;
                  end
                  first_q.insert(slot, ent);
               end
            end
            ACT_MOVE: begin
               // empty source is checked ahead of a full target
               if (first_q.size() == 0) begin
                  res.status = ST_EMPTY;
               end else if (second_q.size() >= QUEUE_DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  ent              = first_q.pop_front();
                  second_q.push_back(ent);
                  res.moved_tag    = ent.tag;
                  res.moved_rating = ent.rating;
               end
            end
            default: ;
         endcase
         res.first_count  = COUNT_W'(first_q.size());
         res.second_count = COUNT_W'(second_q.size());
         if (first_q.size() > first_peak) first_peak = first_q.size();
         if (second_q.size() > second_peak) second_peak = second_q.size();
         owed_q.push_back(res);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_q.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
            return;
         end
         want = owed_q.pop_front();
         status_seen[want.status]++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.first_count !== want.first_count) begin
            $error("first_count: expected %0d, got %0d", want.first_count, got.first_count);
            errors++;
         end
         if (got.second_count !== want.second_count) begin
            $error("second_count: expected %0d, got %0d", want.second_count,
                   got.second_count);
            errors++;
         end
         if (got.moved_tag !== want.moved_tag) begin
            $error("moved_tag: expected %h, got %h", want.moved_tag, got.moved_tag);
            errors++;
         end
         if (got.moved_rating !== want.moved_rating) begin
            $error("moved_rating: expected %0d, got %0d", want.moved_rating,
                   got.moved_rating);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   piqp_req_if req_ch ();
   piqp_rsp_if rsp_ch ();

   positional_insert_queue_pair uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   queue_pair_tracker tracker = new();

   // Idle mix for the current phase, in percent
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // Set by the stimulus, counted down by the receiver
   int hold_left      = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Sample both channels at the same edge the block does. Requests are noted
   // first; a result is never due at the edge its own item is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            tracker.note_request({req_ch.action, req_ch.name_tag, req_ch.rating,
                                  req_ch.position});
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_result({rsp_ch.status, rsp_ch.first_count, rsp_ch.second_count,
                                  rsp_ch.moved_tag, rsp_ch.moved_rating});
      end
   end

   // Receiver: random stalls per phase, plus a long hold when asked for.
   // One nonblocking write to ready per edge.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: well above the slowest legal run
   initial begin
      #2ms;
      $display("positional_insert_queue_pair verification failed");
      $finish;
   end

   // Offer one item, with random gaps in front of it, and return at the edge
   // where it is taken. Valid stays high straight into the next item when no
   // gap follows, so it is never dropped and raised in the same step.
   task automatic offer_item(input request_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= it.action;
      req_ch.name_tag <= it.name_tag;
      req_ch.rating   <= it.rating;
      req_ch.position <= it.position;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic offer_fields(input logic [ACTION_W-1:0] act, input logic [TAG_W-1:0] tag,
                               input logic signed [RATING_W-1:0] rat,
                               input logic [POS_W-1:0] pos);
      offer_item({act, tag, rat, pos});
   endtask

   // Mostly real queue traffic: inserts and appends dominate, moves are kept
   // rare since the second queue never drains and fills for good after 16.
   function automatic request_type random_item();
      request_type it;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 45)      it.action = ACT_INSERT;
      else if (pick < 83) it.action = ACT_APPEND;
      else if (pick < 97) it.action = ACT_MOVE;
      else                it.action = ACT_UNUSED;
      case ($urandom_range(15))
         0:       it.name_tag = '0;
         1:       it.name_tag = '1;
         default: it.name_tag = {$urandom, $urandom};
      endcase
      case ($urandom_range(15))
         0:       it.rating = 16'sh8000;
         1:       it.rating = 16'sh7fff;
         default: it.rating = RATING_W'($urandom_range(16'hffff, 0));
      endcase
      // mostly positions that land inside or just past the queue; some anywhere
      if ($urandom_range(3) == 0) it.position = POS_W'($urandom_range(31, 0));
      else                        it.position = POS_W'($urandom_range(17, 1));
      return it;
   endfunction

   task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) offer_item(random_item());
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.action   <= ACT_APPEND;
      req_ch.name_tag <= '0;
      req_ch.rating   <= '0;
      req_ch.position <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty source, undefined action, insert into an empty queue,
      // field extremes, head/middle/past-count positions, then fill to full.
      offer_fields(ACT_MOVE,   64'h0123_4567_89ab_cdef, 16'sd5, 5'd1);
      offer_fields(ACT_UNUSED, '1, 16'sh7fff, 5'd31);
      offer_fields(ACT_INSERT, 64'h0000_0000_0000_0007, 16'sd7, 5'd7);
      offer_fields(ACT_APPEND, '1, 16'sh7fff, 5'd0);
      offer_fields(ACT_APPEND, '0, 16'sh8000, 5'd0);
      offer_fields(ACT_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, -16'sd1, 5'd0);   // zero -> head
      offer_fields(ACT_INSERT, 64'h5a5a_5a5a_5a5a_5a5a, 16'sd1, 5'd1);    // head
      offer_fields(ACT_INSERT, 64'h8000_0000_0000_0001, 16'sd300, 5'd3);  // middle
      offer_fields(ACT_INSERT, 64'h7fff_ffff_ffff_fffe, -16'sd300, 5'd31);
      offer_fields(ACT_INSERT, 64'h0000_0000_ffff_ffff, 16'sd17, 5'd17);
      offer_fields(ACT_INSERT, 64'hffff_ffff_0000_0000, 16'sd8, 5'd8);    // before tail
      offer_fields(ACT_INSERT, 64'h1111_2222_3333_4444, 16'sd10, 5'd10);  // one past count
      offer_fields(ACT_MOVE,   '0, 16'sd0, 5'd0);
      offer_fields(ACT_MOVE,   '1, 16'sh7fff, 5'd31);
      offer_fields(ACT_UNUSED, '0, 16'sh8000, 5'd0);
      // eight entries left; top the first queue off, then knock on it while full
      repeat (8) offer_fields(ACT_APPEND, {$urandom, $urandom},
                              RATING_W'($urandom_range(16'hffff, 0)), 5'd1);
      offer_fields(ACT_APPEND, 64'hdead_0000_0000_beef, 16'sd2, 5'd2);
      offer_fields(ACT_INSERT, 64'hbeef_0000_0000_dead, -16'sd2, 5'd1);

      // Random phases with the various idle mixes
      random_phase(0, 0, ITEMS_PER_PHASE);
      random_phase(57, 0, ITEMS_PER_PHASE);
      random_phase(0, 57, ITEMS_PER_PHASE);
      random_phase(18, 18, ITEMS_PER_PHASE);

      // Back pressure: receiver holds ready low for a long stretch while the
      // sender keeps offering, so both stages fill and req ready drops.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) offer_item(random_item());

      req_ch.valid <= 1'b0;

      // Drain, then give the two-stage pipe a few spare edges for strays
      while (tracker.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("%0d items accepted: %0d done, %0d refused on full, %0d refused on empty",
               tracker.accepted, tracker.status_seen[ST_DONE], tracker.status_seen[ST_FULL],
               tracker.status_seen[ST_EMPTY]);
      $display("idle mixes none/sender/receiver/both plus one long hold; queue peaks %0d, %0d",
               tracker.first_peak, tracker.second_peak);
      if (tracker.errors == 0) begin
         $display("positional_insert_queue_pair verification clean");
      end else begin
         $display("positional_insert_queue_pair verification failed");
      end
      $finish;
   end

endmodule

// File: positional_insert_queue_pair.f
rtl/piqp_pkg.sv
rtl/piqp_req_if.sv
rtl/piqp_rsp_if.sv
rtl/piqp_first_q.sv
rtl/piqp_second_q.sv
rtl/positional_insert_queue_pair.sv
verif/testbench.sv
